/* src/timer_table_earliest_deadline_core_macros.svh */
// Assertion macros used by the checker file of the timer table.
// Depends on nothing; included by the checker module.
`ifndef TIMER_TABLE_EARLIEST_DEADLINE_CORE_MACROS_SVH
`define TIMER_TABLE_EARLIEST_DEADLINE_CORE_MACROS_SVH

// Assert an implication that is checked while reset is released.
`define TTED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert an implication whose consequent is checked in the next cycle.
`define TTED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tted_pkg.sv */
// Package of the timer table: field widths, function and status codes, defaults.
// Depends on nothing.
`default_nettype none
package tted_pkg;
    localparam int unsigned SLOTS_DEF = 16;
    localparam int unsigned ID_W = 32;
    localparam int unsigned IV_W = 32;
    localparam int unsigned TM_W = 64;

    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_TICK   = 2'd2;
    localparam logic [1:0] FN_ANSWER = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NOFIRE   = 3'd4;

    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] timer_id;
        logic [IV_W-1:0] interval_ms;
    } t_req;

    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      status;
        logic            fired;
        logic [ID_W-1:0] result_id;
        logic [IV_W-1:0] result_interval;
    } t_rsp;
endpackage
`default_nettype wire

/* src/tted_if.sv */
// Valid/ready channel interface carrying one payload struct per beat.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface tted_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/timer_table_earliest_deadline_core.sv */
// Timer table top level: slot memories, scan sequencer and result register.
// Depends on tted_pkg and the tted_if channel interface.
//
// The block keeps up to SLOTS software timers. Each request beat (add, remove,
// tick or answer) yields exactly one reply beat. A request is taken when the
// block is idle. The sequencer then walks the slots one per cycle through a
// synchronous slot memory with a registered read port. After the scan, a
// final state decides the write-back and registers the reply beat, which is
// then offered. The reply beat is held until it is taken, and the next request
// is taken only once the block is idle again, so a request is finished before
// the next is accepted and every reply-side stall holds off the next request.
// The final state writes back at most one slot, and the memory is not read
// again until the next request's scan. Valid bits are in flip-flops cleared by
// reset; the id, interval and deadline words live in memory and are only used
// where their valid bit is set.
`default_nettype none
module timer_table_earliest_deadline_core #(
    parameter int unsigned SLOTS = tted_pkg::SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tted_if.sink      i_req,
    tted_if.source    o_rsp
);
    import tted_pkg::*;

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 2);
    localparam logic [CW-1:0] LAST = CW'(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Slot memory: id, interval and deadline packed into one word.
    localparam int unsigned MW = ID_W + IV_W + TM_W;
    logic [MW-1:0] r_mem [SLOTS];
    logic [MW-1:0] r_rd;
    logic [SLOTS-1:0] r_vld;

    logic [1:0]      r_st;
    t_req            r_req;
    logic [CW-1:0]   r_cnt;
    logic [TM_W-1:0] r_now;
    logic [ID_W-1:0] r_idc;
    logic            r_await;
    logic [ID_W-1:0] r_awid;
    // Best match so far during the scan.
    logic            r_hit;
    logic [AW-1:0]   r_hidx;
    logic [ID_W-1:0] r_hid;
    logic [IV_W-1:0] r_hiv;
    logic [TM_W-1:0] r_hdl;
    logic            r_free;
    logic [AW-1:0]   r_fidx;
    t_rsp            r_rsp;
    t_rsp            n_rsp;

    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   cur;
    logic [ID_W-1:0] m_id;
    logic [IV_W-1:0] m_iv;
    logic [TM_W-1:0] m_dl;
    logic            look;
    logic [ID_W-1:0] key;
    logic            take;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [MW-1:0]   wr_data;
    logic [TM_W-1:0] new_dl;

    assign rd_addr = r_cnt[AW-1:0];
    assign cur = AW'(r_cnt - CW'(1));
    assign {m_id, m_iv, m_dl} = r_rd;
    assign new_dl = r_now + TM_W'(r_req.interval_ms);
    assign key = (r_req.func == FN_ANSWER) ? r_awid : r_req.timer_id;
    assign look = r_vld[cur] && (r_st == S_SCAN) && (r_cnt != '0);

    always_comb begin
        take = 1'b0;
        if (look) begin
            case (r_req.func)
                FN_TICK: begin
                    take = !r_await && (m_dl <= r_now) &&
                           (!r_hit || m_dl < r_hdl || (m_dl == r_hdl && m_id < r_hid));
                end
                FN_REMOVE, FN_ANSWER: begin
                    take = !r_hit && (m_id == key);
                end
                default: take = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_SCAN && r_cnt < LAST) begin
            r_rd <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Write-back decided in the final state.
    always_comb begin
        wr_en = 1'b0;
        wr_addr = r_hidx;
        wr_data = {r_hid, r_req.interval_ms, new_dl};
        if (r_st == S_FIN) begin
            case (r_req.func)
                FN_ADD: begin
                    wr_en = r_free && (r_req.interval_ms != '0);
                    wr_addr = r_fidx;
                    wr_data = {r_idc, r_req.interval_ms, new_dl};
                end
                FN_ANSWER: begin
                    wr_en = r_await && (r_req.timer_id == r_awid) && r_hit &&
                            (r_req.interval_ms != '0);
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    // Reply beat built from the scan result; registered in the final state.
    always_comb begin
        n_rsp = '0;
        n_rsp.kind = r_req.func;
        n_rsp.status = ST_OK;
        case (r_req.func)
            FN_ADD: begin
                if (r_req.interval_ms == '0) begin
                    n_rsp.status = ST_ZERO;
                end else if (!r_free) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.result_id = r_idc;
                end
            end
            FN_REMOVE: begin
                if (!r_hit) begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
            FN_TICK: begin
                if (r_hit) begin
                    n_rsp.fired = 1'b1;
                    n_rsp.result_id = r_hid;
                    n_rsp.result_interval = r_hiv;
                end else begin
                    n_rsp.status = ST_NOFIRE;
                end
            end
            default: begin
                if (!r_await || r_req.timer_id != r_awid || !r_hit) begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
        endcase
    end

    assign i_req.ready = (r_st == S_IDLE);
    assign o_rsp.valid = (r_st == S_OUT);
    assign o_rsp.data = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_vld <= '0;
            r_now <= '0;
            r_idc <= ID_W'(1);
            r_await <= 1'b0;
            r_awid <= '0;
            r_cnt <= '0;
            r_hit <= 1'b0;
            r_free <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_cnt <= '0;
                        r_hit <= 1'b0;
                        r_free <= 1'b0;
                        r_st <= S_SCAN;
                        if (i_req.data.func == FN_TICK) begin
                            r_now <= r_now + TM_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_hit <= 1'b1;
                        r_hidx <= cur;
                        r_hid <= m_id;
                        r_hiv <= m_iv;
                        r_hdl <= m_dl;
                    end
                    if (r_cnt != '0 && !r_vld[cur] && !r_free) begin
                        r_free <= 1'b1;
                        r_fidx <= cur;
                    end
                    if (r_cnt == LAST) begin
                        r_st <= S_FIN;
                    end
                    r_cnt <= r_cnt + CW'(1);
                end
                S_FIN: begin
                    r_rsp <= n_rsp;
                    case (r_req.func)
                        FN_ADD: begin
                            if (r_req.interval_ms != '0 && r_free) begin
                                r_vld[r_fidx] <= 1'b1;
                                r_idc <= (r_idc + ID_W'(1) == '0) ? ID_W'(1) : r_idc + ID_W'(1);
                            end
                        end
                        FN_REMOVE: begin
                            if (r_hit) begin
                                r_vld[r_hidx] <= 1'b0;
                            end
                        end
                        FN_TICK: begin
                            if (r_hit) begin
                                r_await <= 1'b1;
                                r_awid <= r_hid;
                            end
                        end
                        default: begin
                            if (r_await && r_req.timer_id == r_awid) begin
                                r_await <= 1'b0;
                                if (r_hit && r_req.interval_ms == '0) begin
                                    r_vld[r_hidx] <= 1'b0;
                                end
                            end
                        end
                    endcase
                    r_st <= S_OUT;
                end
                default: begin
                    if (o_rsp.ready) begin
                        r_st <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/tted_chk.sv */
// Port-level checker for the timer table, bound to the top level.
// Depends on tted_pkg and the assertion macro header.
`default_nettype none
`include "timer_table_earliest_deadline_core_macros.svh"
module tted_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire tted_pkg::t_rsp rsp_data
);
    import tted_pkg::*;

    // A request is never taken while a reply is pending.
    `TTED_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, rsp_valid, !req_ready)
    // Only a tick reply may report a fire.
    `TTED_ASSERT_IMP(a_fire_tick, i_clk, i_rst_n, rsp_valid && rsp_data.fired,
        rsp_data.kind == FN_TICK && rsp_data.status == ST_OK)
    // A successful add never hands out id zero.
    `TTED_ASSERT_IMP(a_id_nz, i_clk, i_rst_n,
        rsp_valid && rsp_data.kind == FN_ADD && rsp_data.status == ST_OK,
        rsp_data.result_id != '0)
    // An accepted request is not followed by a reply in the next cycle.
    `TTED_ASSERT_NEXT(a_lat, i_clk, i_rst_n, req_valid && req_ready, !rsp_valid)
    // A stalled reply beat stays offered and unchanged.
    `TTED_ASSERT_NEXT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_data))
endmodule

bind timer_table_earliest_deadline_core tted_chk u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .req_valid(i_req.valid),
    .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid),
    .rsp_ready(o_rsp.ready),
    .rsp_data(o_rsp.data)
);
`default_nettype wire
